### src/gda_pkg.sv
// Shared types, constants and helper functions of the Gregorian date adder.
// No dependencies; the pipeline modules, the top level and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package gda_pkg;

  localparam int unsigned YEAR_MIN     = 1900;
  localparam int unsigned MAX_YEAR_DEF = 9999;

  typedef enum logic [1:0] {
    OP_DAYS   = 2'd0,
    OP_MONTHS = 2'd1,
    OP_YEARS  = 2'd2,
    OP_NONE   = 2'd3
  } gda_op_t;

  // Reciprocal constants: floor(x / D) == (x * M) >> S for every x below 2**(S - ceil(log2 D)).
  localparam int unsigned S100    = 21;
  localparam logic [31:0] M100    = 32'(((longint'(1) <<< S100) + 100 - 1) / 100);
  localparam int unsigned S12     = 22;
  localparam logic [31:0] M12     = 32'(((longint'(1) <<< S12) + 12 - 1) / 12);
  localparam int unsigned S146097 = 41;
  localparam logic [31:0] M146097 = 32'(((longint'(1) <<< S146097) + 146097 - 1) / 146097);
  localparam int unsigned S1460   = 29;
  localparam logic [31:0] M1460   = 32'(((longint'(1) <<< S1460) + 1460 - 1) / 1460);
  localparam int unsigned S365    = 27;
  localparam logic [31:0] M365    = 32'(((longint'(1) <<< S365) + 365 - 1) / 365);
  localparam int unsigned S7      = 14;
  localparam logic [31:0] M7      = 32'(((longint'(1) <<< S7) + 7 - 1) / 7);

  typedef struct packed {
    gda_op_t            op;
    logic [4:0]         d;
    logic [3:0]         m;
    logic [13:0]        y;
    logic signed [22:0] amt;
    logic               bad;
    logic [7:0]         qy;
    logic [13:0]        yy;
    logic [8:0]         doy;
    logic [7:0]         c;
    logic signed [25:0] t;
    logic signed [25:0] nyr;
    logic               tok;
    logic               nyok;
    logic [13:0]        tq;
    logic [23:0]        zb;
    logic signed [25:0] z;
    logic               zok;
    logic [13:0]        ny;
    logic [3:0]         tm;
    logic               rok;
    logic [7:0]         qn;
    logic               nok;
    logic [5:0]         era;
    logic [17:0]        doe;
    logic [6:0]         a;
    logic [2:0]         b;
    logic               e;
    logic [17:0]        n;
    logic [8:0]         yoe;
    logic [8:0]         cdoy;
    logic [3:0]         mp;
    logic [4:0]         cd;
    logic [3:0]         cm;
    logic [13:0]        cy;
    logic [4:0]         fd;
    logic [3:0]         fm;
    logic [13:0]        fy;
    logic               ok;
    logic [3:0]         wm;
    logic [13:0]        wy;
    logic [7:0]         j;
    logic [10:0]        f;
    logic [7:0]         q7;
    logic [2:0]         wd;
  } gda_pipe_t;

  function automatic logic [23:0] rdiv(input logic [23:0] x, input logic [31:0] mul,
                                       input int unsigned sh);
    logic [55:0] p;
    p = 56'(x) * 56'(mul);
    return 24'(p >> sh);
  endfunction

  // q is y / 100
  function automatic logic is_leap(input logic [13:0] y, input logic [7:0] q);
    logic [13:0] h;
    h = 14'(q) * 14'd100;
    return (y[1:0] == 2'b00) && ((y != h) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] mlen(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m) inside
      4'd2:                     r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
      default:                  r = 5'd31;
    endcase
    return r;
  endfunction

  // First day of month index mp in a March-based year
  function automatic logic [8:0] mstart(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Zeller month term 13*(m+1)/5 for m = 3..14
  function automatic logic [5:0] zel(input logic [3:0] m);
    logic [5:0] r;
    case (m)
      4'd3:    r = 6'd10;
      4'd4:    r = 6'd13;
      4'd5:    r = 6'd15;
      4'd6:    r = 6'd18;
      4'd7:    r = 6'd20;
      4'd8:    r = 6'd23;
      4'd9:    r = 6'd26;
      4'd10:   r = 6'd28;
      4'd11:   r = 6'd31;
      4'd12:   r = 6'd33;
      4'd13:   r = 6'd36;
      4'd14:   r = 6'd39;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### src/gda_req_if.sv
// Request channel of the date adder: valid/ready plus the request fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface gda_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [4:0]         in_day;
  logic [3:0]         in_month;
  logic [13:0]        in_year;
  logic signed [22:0] amount;

  modport source (output valid, operation, in_day, in_month, in_year, amount, input ready);
  modport sink   (input valid, operation, in_day, in_month, in_year, amount, output ready);
endinterface

`default_nettype wire

### src/gda_rsp_if.sv
// Result channel of the date adder: valid/ready plus the result fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface gda_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [13:0] out_year;
  logic        ok;
  logic        input_was_invalid;
  logic [2:0]  weekday;

  modport source (output valid, out_day, out_month, out_year, ok, input_was_invalid, weekday,
                  input ready);
  modport sink   (input valid, out_day, out_month, out_year, ok, input_was_invalid, weekday,
                  output ready);
endinterface

`default_nettype wire

### src/gda_front.sv
// Front pipeline: input check and replacement, day number, month and year paths.
// Depends on gda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gda_front
  import gda_pkg::*;
#(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      in_vld,
  input  wire gda_pipe_t in_p,
  output logic           out_vld,
  output gda_pipe_t      out_p
);

  localparam int NS = 8;
  localparam int Z_LO = 365 * 1899 + 1899 / 4 - 1899 / 100 + 1899 / 400 + 306;
  localparam int Z_HI = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400 + 305;
  localparam logic signed [25:0] ZLO_S  = 26'(Z_LO);
  localparam logic signed [25:0] ZHI_S  = 26'(Z_HI);
  localparam logic signed [25:0] TLO_S  = 26'(YEAR_MIN * 12);
  localparam logic signed [25:0] THI_S  = 26'(MAX_YEAR * 12 + 11);
  localparam logic signed [25:0] YLO_S  = 26'(YEAR_MIN);
  localparam logic signed [25:0] YHI_S  = 26'(MAX_YEAR);
  localparam logic [13:0]        YMIN14 = 14'(YEAR_MIN);
  localparam logic [13:0]        YMAX14 = 14'(MAX_YEAR);

  logic [NS-1:0] vld;
  gda_pipe_t s1, s2, s3, s4, s5, s6, s7, s8;
  gda_pipe_t s2_next, s3_next, s4_next, s5_next, s6_next, s7_next, s8_next;

  logic [3:0]  mp4;
  logic [17:0] rem12;
  logic        in_ok;

  always_comb begin
    s2_next    = s1;
    s2_next.qy = 8'(rdiv(24'(s1.y), M100, S100));

    // replace an impossible start date by 1 January 1900
    in_ok = (s2.y >= YMIN14) && (s2.y <= YMAX14) && (s2.m >= 4'd1) && (s2.m <= 4'd12) &&
            (s2.d != 5'd0) && (s2.d <= mlen(s2.m, is_leap(s2.y, s2.qy)));
    s3_next     = s2;
    s3_next.bad = !in_ok;
    if (!in_ok) begin
      s3_next.d = 5'd1;
      s3_next.m = 4'd1;
      s3_next.y = YMIN14;
    end

    s4_next      = s3;
    s4_next.yy   = (s3.m <= 4'd2) ? s3.y - 14'd1 : s3.y;
    mp4          = (s3.m > 4'd2) ? s3.m - 4'd3 : s3.m + 4'd9;
    s4_next.doy  = mstart(mp4) + 9'(s3.d) - 9'd1;
    s4_next.t    = $signed(26'(s3.y)) * 26'sd12 + $signed(26'(s3.m)) - 26'sd1 + 26'(s3.amt);
    s4_next.nyr  = $signed(26'(s3.y)) + 26'(s3.amt);
    s4_next.tok  = 1'b0;
    s4_next.nyok = 1'b0;

    s5_next      = s4;
    s5_next.tok  = (s4.t >= TLO_S) && (s4.t <= THI_S);
    s5_next.nyok = (s4.nyr >= YLO_S) && (s4.nyr <= YHI_S);
    s5_next.c    = 8'(rdiv(24'(s4.yy), M100, S100));
    s5_next.tq   = 14'(rdiv(24'(s4.t[17:0]), M12, S12));

    s6_next    = s5;
    s6_next.zb = 24'(s5.yy) * 24'd365 + 24'(s5.yy >> 2) - 24'(s5.c) + 24'(s5.c >> 2) +
                 24'(s5.doy);
    rem12      = s5.t[17:0] - 18'(s5.tq) * 18'd12;
    if (s5.op == OP_MONTHS) begin
      s6_next.tm  = 4'(rem12) + 4'd1;
      s6_next.ny  = s5.tq;
      s6_next.rok = s5.tok;
    end else begin
      s6_next.tm  = s5.m;
      s6_next.ny  = s5.nyr[13:0];
      s6_next.rok = s5.nyok;
    end

    s7_next     = s6;
    s7_next.z   = $signed(26'(s6.zb)) + 26'(s6.amt);
    s7_next.zok = 1'b0;
    s7_next.qn  = 8'(rdiv(24'(s6.ny), M100, S100));

    s8_next     = s7;
    s8_next.zok = (s7.z >= ZLO_S) && (s7.z <= ZHI_S);
    s8_next.nok = s7.rok && (s7.d <= mlen(s7.tm, is_leap(s7.ny, s7.qn)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= in_p;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
      s6 <= s6_next;
      s7 <= s7_next;
      s8 <= s8_next;
    end
  end

  assign out_vld = vld[NS-1];
  assign out_p   = s8;

endmodule

`default_nettype wire

### src/gda_civil.sv
// Civil pipeline: day number back to year, month and day of month.
// Depends on gda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gda_civil
  import gda_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      in_vld,
  input  wire gda_pipe_t in_p,
  output logic           out_vld,
  output gda_pipe_t      out_p
);

  localparam int NS = 8;

  logic [NS-1:0] vld;
  gda_pipe_t c1, c2, c3, c4, c5, c6, c7, c8;
  gda_pipe_t c1_next, c2_next, c3_next, c4_next, c5_next, c6_next, c7_next, c8_next;

  logic [1:0] h;
  logic [3:0] cnt;

  always_comb begin
    // only meaningful when the day number is in range
    c1_next     = in_p;
    c1_next.era = 6'(rdiv(24'(in_p.z[22:0]), M146097, S146097));

    c2_next     = c1;
    c2_next.doe = 18'(c1.z[22:0] - 23'(c1.era) * 23'd146097);

    c3_next   = c2;
    c3_next.a = 7'(rdiv(24'(c2.doe), M1460, S1460));
    c3_next.b = 3'(c2.doe >= 18'd36524) + 3'(c2.doe >= 18'd73048) +
                3'(c2.doe >= 18'd109572) + 3'(c2.doe >= 18'd146096);
    c3_next.e = (c2.doe == 18'd146096);

    c4_next   = c3;
    c4_next.n = c3.doe - 18'(c3.a) + 18'(c3.b) - 18'(c3.e);

    c5_next     = c4;
    c5_next.yoe = 9'(rdiv(24'(c4.n), M365, S365));

    h = 2'(c5.yoe >= 9'd100) + 2'(c5.yoe >= 9'd200) + 2'(c5.yoe >= 9'd300);
    c6_next      = c5;
    c6_next.cdoy = 9'(c5.doe - (18'(c5.yoe) * 18'd365 + 18'(c5.yoe >> 2) - 18'(h)));

    cnt = '0;
    for (int i = 1; i < 12; i++) begin
      cnt = cnt + 4'(c6.cdoy >= mstart(4'(i)));
    end
    c7_next    = c6;
    c7_next.mp = cnt;

    c8_next    = c7;
    c8_next.cd = 5'(c7.cdoy - mstart(c7.mp) + 9'd1);
    c8_next.cm = (c7.mp < 4'd10) ? c7.mp + 4'd3 : c7.mp - 4'd9;
    c8_next.cy = 14'(c7.yoe) + 14'(c7.era) * 14'd400 + 14'(c7.mp >= 4'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= c1_next;
      c2 <= c2_next;
      c3 <= c3_next;
      c4 <= c4_next;
      c5 <= c5_next;
      c6 <= c6_next;
      c7 <= c7_next;
      c8 <= c8_next;
    end
  end

  assign out_vld = vld[NS-1];
  assign out_p   = c8;

endmodule

`default_nettype wire

### src/gda_wday.sv
// Result pipeline: picks the returned date and computes its weekday (Zeller).
// Depends on gda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gda_wday
  import gda_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      in_vld,
  input  wire gda_pipe_t in_p,
  output logic           out_vld,
  output gda_pipe_t      out_p
);

  localparam int NS = 6;

  logic [NS-1:0] vld;
  gda_pipe_t w1, w2, w3, w4, w5, w6;
  gda_pipe_t w1_next, w2_next, w3_next, w4_next, w5_next, w6_next;

  logic [6:0] k;
  logic [2:0] r;

  always_comb begin
    w1_next = in_p;
    case (in_p.op)
      OP_DAYS:   w1_next.ok = in_p.zok;
      OP_MONTHS: w1_next.ok = in_p.nok;
      OP_YEARS:  w1_next.ok = in_p.nok;
      default:   w1_next.ok = 1'b0;
    endcase
    if (!w1_next.ok) begin
      w1_next.fd = in_p.d;
      w1_next.fm = in_p.m;
      w1_next.fy = in_p.y;
    end else if (in_p.op == OP_DAYS) begin
      w1_next.fd = in_p.cd;
      w1_next.fm = in_p.cm;
      w1_next.fy = in_p.cy;
    end else begin
      w1_next.fd = in_p.d;
      w1_next.fm = in_p.tm;
      w1_next.fy = in_p.ny;
    end

    // January and February count as months 13 and 14 of the year before
    w2_next = w1;
    if (w1.fm < 4'd3) begin
      w2_next.wm = w1.fm + 4'd12;
      w2_next.wy = w1.fy - 14'd1;
    end else begin
      w2_next.wm = w1.fm;
      w2_next.wy = w1.fy;
    end

    w3_next   = w2;
    w3_next.j = 8'(rdiv(24'(w2.wy), M100, S100));

    k         = 7'(w3.wy - 14'(w3.j) * 14'd100);
    w4_next   = w3;
    w4_next.f = 11'(w3.fd) + 11'(zel(w3.wm)) + 11'(k) + 11'(k >> 2) + 11'(w3.j >> 2) +
                11'(w3.j) * 11'd5;

    w5_next    = w4;
    w5_next.q7 = 8'(rdiv(24'(w4.f), M7, S7));

    r          = 3'(w5.f - 11'(w5.q7) * 11'd7);
    w6_next    = w5;
    w6_next.wd = (r >= 3'd2) ? r - 3'd2 : r + 3'd5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1 <= w1_next;
      w2 <= w2_next;
      w3 <= w3_next;
      w4 <= w4_next;
      w5 <= w5_next;
      w6 <= w6_next;
    end
  end

  assign out_vld = vld[NS-1];
  assign out_p   = w6;

endmodule

`default_nettype wire

### src/gregorian_date_adder.sv
// Top level of the Gregorian date adder: handshake and the three pipeline sections.
// Depends on gda_pkg, gda_req_if, gda_rsp_if, gda_front, gda_civil, gda_wday.
//
//   channel | dir | payload
//   req     | in  | operation, in_day, in_month, in_year, amount
//   rsp     | out | out_day, out_month, out_year, ok, input_was_invalid, weekday
//
// One request enters per cycle while no result is held on rsp; a result passes through the
// 22 register stages (8 front, 8 civil, 6 weekday) before it is valid on rsp and can leave.
// rst is synchronous and clears only the stage valid bits.
// A result held on rsp freezes the whole pipeline and drops req.ready; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_adder
  import gda_pkg::*;
#(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input wire logic clk,
  input wire logic rst,
  gda_req_if.sink  req,
  gda_rsp_if.source rsp
);

  logic      en;
  logic      f_vld, c_vld, w_vld;
  gda_pipe_t req_p, f_p, c_p, w_p;

  assign en        = !w_vld || rsp.ready;
  assign req.ready = en;

  always_comb begin
    req_p     = '0;
    req_p.op  = gda_op_t'(req.operation);
    req_p.d   = req.in_day;
    req_p.m   = req.in_month;
    req_p.y   = req.in_year;
    req_p.amt = req.amount;
  end

  gda_front #(.MAX_YEAR(MAX_YEAR)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(req.valid), .in_p(req_p),
    .out_vld(f_vld), .out_p(f_p)
  );

  gda_civil u_civil (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(f_vld), .in_p(f_p),
    .out_vld(c_vld), .out_p(c_p)
  );

  gda_wday u_wday (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(c_vld), .in_p(c_p),
    .out_vld(w_vld), .out_p(w_p)
  );

  assign rsp.valid             = w_vld;
  assign rsp.out_day           = w_p.fd;
  assign rsp.out_month         = w_p.fm;
  assign rsp.out_year          = w_p.fy;
  assign rsp.ok                = w_p.ok;
  assign rsp.input_was_invalid = w_p.bad;
  assign rsp.weekday           = w_p.wd;

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.out_year >= 14'(YEAR_MIN)) && (rsp.out_year <= 14'(MAX_YEAR)))
    else $error("result year out of range");

  a_date_shape: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.out_month >= 4'd1) && (rsp.out_month <= 4'd12) && (rsp.out_day != 5'd0))
    else $error("result month or day malformed");

  a_replaced_fail: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.input_was_invalid && !rsp.ok |->
      (rsp.out_day == 5'd1) && (rsp.out_month == 4'd1) && (rsp.out_year == 14'(YEAR_MIN)))
    else $error("failed request on replaced date did not return 1/1/1900");

  a_weekday: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.weekday <= 3'd6)
    else $error("weekday out of range");

endmodule

`default_nettype wire

### tb/sv/tb_gregorian_date_adder.sv
// Testbench of the Gregorian date adder: directed and random requests, and a
// scoreboard that works out each expected date, flags and weekday.
// Depends on gda_pkg, gda_req_if, gda_rsp_if and gregorian_date_adder.
`timescale 1ns / 1ps

module tb_gregorian_date_adder;
  import gda_pkg::*;

  localparam int LAST_YEAR = MAX_YEAR_DEF;
  localparam int N_RANDOM  = 1200;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        ok;
    logic        bad;
    logic [2:0]  wday;
  } date_result_t;

  class date_scoreboard;
    date_result_t pending[$];
    int errors;

    function automatic bit leap(longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint days_in(longint m, longint y);
      if (m == 2) return leap(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    function automatic bit valid_date(longint d, longint m, longint y);
      if (y < longint'(YEAR_MIN) || y > LAST_YEAR || m < 1 || m > 12 || d < 1) return 0;
      return d <= days_in(m, y);
    endfunction

    // days counted from 1 March of year 0
    function automatic longint serial(longint y, longint m, longint d);
      longint yy, era, yoe, mp, doy;
      yy = (m <= 2) ? y - 1 : y;
      era = yy / 400;
      yoe = yy - era * 400;
      mp = (m > 2) ? m - 3 : m + 9;
      doy = (153 * mp + 2) / 5 + d - 1;
      return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
    endfunction

    function automatic void civil(longint z, output longint y, output longint m,
                                  output longint d);
      longint era, doe, yoe, doy, mp;
      era = z / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      m = (mp < 10) ? mp + 3 : mp - 9;
      d = doy - (153 * mp + 2) / 5 + 1;
      y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    endfunction

    // Zeller, remapped so Monday is 0
    function automatic longint zeller(longint d, longint m, longint y);
      longint k, j;
      if (m < 3) begin
        m += 12;
        y -= 1;
      end
      k = y % 100;
      j = y / 100;
      return ((d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7 + 5) % 7;
    endfunction

    function automatic void note_request(gda_op_t op, logic [4:0] di, logic [3:0] mi,
                                         logic [13:0] yi, logic signed [22:0] amt);
      longint d, m, y, nd, nm, ny, z, t, a;
      bit ok, bad;
      date_result_t r;
      d = di; m = mi; y = yi; a = amt;
      ok = 0; bad = 0; nd = 0; nm = 0; ny = 0;
      if (!valid_date(d, m, y)) begin
        d = 1; m = 1; y = YEAR_MIN; bad = 1;
      end
      case (op)
        OP_DAYS: begin
          z = serial(y, m, d) + a;
          if (z >= serial(YEAR_MIN, 1, 1) && z <= serial(LAST_YEAR, 12, 31)) begin
            civil(z, ny, nm, nd);
            ok = 1;
          end
        end
        OP_MONTHS: begin
          t = y * 12 + (m - 1) + a;
          if (t >= longint'(YEAR_MIN) * 12 && t <= longint'(LAST_YEAR) * 12 + 11) begin
            ny = t / 12;
            nm = t % 12 + 1;
            nd = d;
            ok = nd <= days_in(nm, ny);
          end
        end
        OP_YEARS: begin
          ny = y + a; nm = m; nd = d;
          ok = valid_date(nd, nm, ny);
        end
        default: ok = 0;
      endcase
      if (ok) begin
        d = nd; m = nm; y = ny;
      end
      r.day = d[4:0]; r.month = m[3:0]; r.year = y[13:0];
      r.ok = ok; r.bad = bad; r.wday = 3'(zeller(d, m, y));
      pending.insert(pending.size(), r);
    endfunction

    function automatic void check_result(date_result_t got);
      date_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0d/%0d/%0d", got.day, got.month,
                                   got.year);
        return;
      end
      exp_r = pending.pop_front();
      if (got != exp_r) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp d%0d m%0d y%0d ok%0d bad%0d wd%0d",
                    " got d%0d m%0d y%0d ok%0d bad%0d wd%0d"},
                   exp_r.day, exp_r.month, exp_r.year, exp_r.ok, exp_r.bad, exp_r.wday,
                   got.day, got.month, got.year, got.ok, got.bad, got.wday);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  bit calm = 0;
  bit sending = 1;
  date_scoreboard sb;

  gda_req_if req ();
  gda_rsp_if rsp ();

  gregorian_date_adder DUT (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    req.valid = 0;
    req.operation = 0;
    req.in_day = 0;
    req.in_month = 0;
    req.in_year = 0;
    req.amount = 0;
    rsp.ready = 0;
  end

  // result side: random stalls, sample at the rising edge
  always @(negedge clk) begin
    rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin
    date_result_t g;
    if (!rst && rsp.valid && rsp.ready) begin
      g.day = rsp.out_day; g.month = rsp.out_month; g.year = rsp.out_year;
      g.ok = rsp.ok; g.bad = rsp.input_was_invalid; g.wday = rsp.weekday;
      sb.check_result(g);
    end
  end

  // called at a falling edge; valid stays high after a transfer until the next
  // request or idle cycle replaces it
  task automatic send(gda_op_t op, logic [4:0] d, logic [3:0] m, logic [13:0] y,
                      logic signed [22:0] amt);
    while (!calm && $urandom_range(99) < 29) begin
      req.valid <= 0;
      @(negedge clk);
    end
    req.valid <= 1;
    req.operation <= op;
    req.in_day <= d;
    req.in_month <= m;
    req.in_year <= y;
    req.amount <= amt;
    do @(posedge clk); while (!req.ready);
    sb.note_request(op, d, m, y, amt);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [4:0] d;
    logic [3:0] m;
    logic [13:0] y;
    logic signed [22:0] amt;
    gda_op_t op;
    op = gda_op_t'(2'($urandom_range(3)));
    if ($urandom_range(9) < 8) begin
      y = 14'($urandom_range(LAST_YEAR, YEAR_MIN));
      m = 4'($urandom_range(12, 1));
      d = 5'($urandom_range(31, 1));
      if ($urandom_range(3) == 0) begin
        m = 4'd2; d = 5'd29;
        y = 14'(4 * $urandom_range(LAST_YEAR / 4, YEAR_MIN / 4));
      end
    end else begin
      d = 5'($urandom); m = 4'($urandom); y = 14'($urandom);
    end
    case ($urandom_range(4))
      0: amt = 23'($urandom);
      1: amt = $signed(23'($urandom_range(2000))) - 23'sd1000;
      2: amt = $signed(23'($urandom_range(8000000))) - 23'sd4000000;
      3: amt = $signed(23'($urandom_range(200000))) - 23'sd100000;
      default: amt = $signed(23'($urandom_range(20000))) - 23'sd10000;
    endcase
    send(op, d, m, y, amt);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send(OP_DAYS, 5'd1, 4'd1, 14'd1900, 23'sd0);
    send(OP_DAYS, 5'd1, 4'd1, 14'd1900, -23'sd1);
    send(OP_DAYS, 5'd31, 4'd12, 14'd9999, 23'sd1);
    send(OP_DAYS, 5'd31, 4'd12, 14'd9999, -23'sd1);
    send(OP_DAYS, 5'd28, 4'd2, 14'd2000, 23'sd1);
    send(OP_DAYS, 5'd28, 4'd2, 14'd1900, 23'sd1);
    send(OP_DAYS, 5'd1, 4'd1, 14'd1900, 23'sd2958463);
    send(OP_DAYS, 5'd15, 4'd6, 14'd5000, 23'h3FFFFF);
    send(OP_DAYS, 5'd15, 4'd6, 14'd5000, 23'h400000);
    send(OP_DAYS, 5'd0, 4'd0, 14'd0, 23'sd10);
    send(OP_DAYS, 5'd31, 4'd15, 14'h3FFF, 23'sd1);
    send(OP_DAYS, 5'd30, 4'd2, 14'd2004, 23'sd0);
    send(OP_DAYS, 5'd1, 4'd1, 14'd10000, 23'sd0);
    send(OP_MONTHS, 5'd31, 4'd1, 14'd2001, 23'sd1);
    send(OP_MONTHS, 5'd31, 4'd1, 14'd2001, 23'sd2);
    send(OP_MONTHS, 5'd1, 4'd1, 14'd1900, -23'sd1);
    send(OP_MONTHS, 5'd1, 4'd12, 14'd9999, 23'sd1);
    send(OP_MONTHS, 5'd10, 4'd3, 14'd1950, 23'h400000);
    send(OP_MONTHS, 5'd10, 4'd3, 14'd1950, 23'h3FFFFF);
    send(OP_YEARS, 5'd29, 4'd2, 14'd2000, 23'sd4);
    send(OP_YEARS, 5'd29, 4'd2, 14'd2000, 23'sd1);
    send(OP_YEARS, 5'd1, 4'd1, 14'd1900, -23'sd1);
    send(OP_YEARS, 5'd31, 4'd12, 14'd1900, 23'sd8099);
    send(OP_NONE, 5'd17, 4'd7, 14'd1969, 23'sd5);
    send(OP_NONE, 5'd31, 4'd4, 14'd1969, 23'sd5);
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 500 && i < 700);
      send_random();
    end
    calm = 0;
    req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
src/gda_pkg.sv
src/gda_req_if.sv
src/gda_rsp_if.sv
src/gda_front.sv
src/gda_civil.sv
src/gda_wday.sv
src/gregorian_date_adder.sv
tb/sv/tb_gregorian_date_adder.sv
